// File: sv/pkcd_pkg.sv
// ----------------------------------------------------------------------------
// pkcd_pkg
// Shared types for the per-key change-detect table: the search word that
// travels down the row of table cells.
// ----------------------------------------------------------------------------
package pkcd_pkg;

   localparam int KEY_WIDTH  = 64;
   localparam int TICK_WIDTH = 64;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]  action_id;
      logic [KEY_WIDTH-1:0]  origin;
      logic                  level;
      logic                  active;
      logic                  changed;
      logic [TICK_WIDTH-1:0] now_ticks;
      logic                  hit;
      logic                  inserted;
      logic [TICK_WIDTH-1:0] found_time;
   } word_type;

endpackage

// File: sv/pkcd_cell.sv
// ----------------------------------------------------------------------------
// pkcd_cell
// One table entry. Compares the passing search word with its key, updates
// or claims the entry, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module pkcd_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [COUNT_WIDTH-1:0]   entry_count,
   input  logic                     in_valid,
   input  pkcd_pkg::word_type       in_word,
   output logic                     out_valid,
   output pkcd_pkg::word_type       out_word
);

   localparam logic [COUNT_WIDTH-1:0] MyIndex = COUNT_WIDTH'(CELL_INDEX);

   logic [pkcd_pkg::KEY_WIDTH-1:0]  action_ff, action_in;
   logic [pkcd_pkg::KEY_WIDTH-1:0]  origin_ff, origin_in;
   logic                            level_ff, level_in;
   logic [pkcd_pkg::TICK_WIDTH-1:0] time_ff, time_in;
   logic                            valid_ff;
   pkcd_pkg::word_type              word_ff, word_in;
   logic                            match;
   logic                            place;
   logic                            diff;

   always_comb begin
      word_in   = in_word;
      action_in = action_ff;
      origin_in = origin_ff;
      level_in  = level_ff;
      time_in   = time_ff;
      match = in_valid && in_word.active && !in_word.hit && (entry_count > MyIndex)
              && (action_ff == in_word.action_id) && (origin_ff == in_word.origin);
      place = in_valid && in_word.active && !in_word.hit && !in_word.inserted
              && (entry_count == MyIndex);
      diff  = level_ff != in_word.level;
      if (match) begin
         word_in.hit        = 1'b1;
         word_in.changed    = diff;
         word_in.found_time = diff ? in_word.now_ticks : time_ff;
         if (diff) begin
            level_in = in_word.level;
            time_in  = in_word.now_ticks;
         end
      end else if (place) begin
         word_in.inserted = 1'b1;
         action_in = in_word.action_id;
         origin_in = in_word.origin;
         level_in  = in_word.level;
         time_in   = in_word.now_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      word_ff   <= word_in;
      action_ff <= action_in;
      origin_ff <= origin_in;
      level_ff  <= level_in;
      time_ff   <= time_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// File: sv/per_key_change_detect_table.sv
// ----------------------------------------------------------------------------
// per_key_change_detect_table
// Change detector for digital button samples keyed by action and origin.
//
// Usage: drive the req_ ports and raise start; the word is taken at a clock
// edge with start high and busy low. busy stays high while the word walks
// the row of TABLE_DEPTH cells, one cell per cycle. Each cell holds one
// table entry, checks the key, and on a hit updates level and change time;
// the first free cell claims a missed key. One result word appears on the
// rsp_ ports for a single cycle, marked by rsp_valid, after the word leaves
// the last cell and is registered; busy drops at the edge that raises
// rsp_valid, so no new word is taken before the last has left the row.
// Latency is set by the walk through the cell row.
// The receiver cannot stall: results must be taken on the strobe.
// Reset empties the table (entry count to zero) and drops any word in
// flight; the entries themselves are not cleared.
// ----------------------------------------------------------------------------
module per_key_change_detect_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_action_id,
   input  logic [63:0] req_origin,
   input  logic        req_level,
   input  logic        req_active,
   input  logic        req_changed_in,
   input  logic [63:0] req_now_ticks,
   output logic        rsp_valid,
   output logic        rsp_changed,
   output logic        rsp_time_written,
   output logic [63:0] rsp_elapsed_ticks,
   output logic        rsp_hit,
   output logic        rsp_inserted,
   output logic        rsp_table_full
);

   localparam int CountWidth = $clog2(TABLE_DEPTH + 1);

   logic                    busy_ff;
   logic [CountWidth-1:0]   count_ff;
   logic                    accept;
   pkcd_pkg::word_type      head_word;
   logic                    chain_valid [TABLE_DEPTH+1];
   pkcd_pkg::word_type      chain_word  [TABLE_DEPTH+1];
   pkcd_pkg::word_type      last;
   logic                    last_valid;

   logic        rsp_valid_ff;
   logic        rsp_changed_ff;
   logic        rsp_time_written_ff;
   logic [63:0] rsp_elapsed_ff;
   logic        rsp_hit_ff;
   logic        rsp_inserted_ff;
   logic        rsp_table_full_ff;

   assign accept = start && !busy_ff;

   always_comb begin
      head_word.action_id  = req_action_id;
      head_word.origin     = req_origin;
      head_word.level      = req_level;
      head_word.active     = req_active;
      head_word.changed    = req_changed_in;
      head_word.now_ticks  = req_now_ticks;
      head_word.hit        = 1'b0;
      head_word.inserted   = 1'b0;
      head_word.found_time = '0;
   end

   assign chain_valid[0] = accept;
   assign chain_word[0]  = head_word;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      pkcd_cell #(
         .CELL_INDEX  (i),
         .COUNT_WIDTH (CountWidth)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .entry_count (count_ff),
         .in_valid    (chain_valid[i]),
         .in_word     (chain_word[i]),
         .out_valid   (chain_valid[i+1]),
         .out_word    (chain_word[i+1])
      );
   end

   assign last       = chain_word[TABLE_DEPTH];
   assign last_valid = chain_valid[TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last_valid;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (last_valid) begin
            busy_ff <= 1'b0;
         end
         if (last_valid && last.inserted) begin
            count_ff <= count_ff + CountWidth'(1);
         end
      end
      rsp_changed_ff      <= last.changed;
      rsp_hit_ff          <= last.hit;
      rsp_inserted_ff     <= last.inserted;
      rsp_table_full_ff   <= last.active && !last.hit && !last.inserted;
      rsp_time_written_ff <= last.hit && (last.found_time != '0);
      rsp_elapsed_ff      <= (last.hit && (last.found_time != '0))
                             ? (last.now_ticks - last.found_time) : '0;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_changed       = rsp_changed_ff;
   assign rsp_time_written  = rsp_time_written_ff;
   assign rsp_elapsed_ticks = rsp_elapsed_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_inserted      = rsp_inserted_ff;
   assign rsp_table_full    = rsp_table_full_ff;

endmodule

// File: sv/pkcd_checker.sv
// ----------------------------------------------------------------------------
// pkcd_checker
// Port-level checks for the per-key change-detect table, bound to the top.
// ----------------------------------------------------------------------------
module pkcd_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_time_written,
   input logic [63:0] rsp_elapsed_ticks,
   input logic        rsp_hit,
   input logic        rsp_inserted,
   input logic        rsp_table_full
);

   a_outcome_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_hit, rsp_inserted, rsp_table_full}))
      else $error("hit, inserted and table_full overlap");

   a_time_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_time_written |-> rsp_hit)
      else $error("time_written without hit");

   a_elapsed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_time_written |-> rsp_elapsed_ticks == '0)
      else $error("elapsed_ticks nonzero without time_written");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted word did not raise busy");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind per_key_change_detect_table pkcd_checker u_pkcd_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_time_written  (rsp_time_written),
   .rsp_elapsed_ticks (rsp_elapsed_ticks),
   .rsp_hit           (rsp_hit),
   .rsp_inserted      (rsp_inserted),
   .rsp_table_full    (rsp_table_full)
);

// File: tb/sv/per_key_change_detect_table_test.sv
// ----------------------------------------------------------------------------
// per_key_change_detect_table_test
// Self-checking bench for the per-key change-detect table. A queue of button
// samples feeds a command-style driver; a clocked monitor predicts each
// accepted word against a private copy of the key table and compares the
// strobed result field by field. Directed samples cover pass-through, zero
// change time, wrap of the elapsed count and near-miss keys; random samples
// fill the table to full and keep hitting the stored keys.
// ----------------------------------------------------------------------------
module per_key_change_detect_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 64;
   localparam int LATENCY    = DEPTH + 1;
   localparam int POOL_SIZE  = 96;
   localparam int LIMIT      = 400000;

   typedef struct packed {
      logic [63:0] action_id;
      logic [63:0] origin;
      logic        level;
      logic        active;
      logic        changed_in;
      logic [63:0] now_ticks;
   } sample_type;

   typedef struct packed {
      logic        changed;
      logic        time_written;
      logic [63:0] elapsed_ticks;
      logic        hit;
      logic        inserted;
      logic        table_full;
   } flags_type;

   typedef struct {
      sample_type  s;
      int unsigned gap;
      bit          drain;
   } pending_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_action_id = '0;
   logic [63:0] req_origin = '0;
   logic        req_level = 1'b0;
   logic        req_active = 1'b0;
   logic        req_changed_in = 1'b0;
   logic [63:0] req_now_ticks = '0;
   logic        rsp_valid;
   logic        rsp_changed;
   logic        rsp_time_written;
   logic [63:0] rsp_elapsed_ticks;
   logic        rsp_hit;
   logic        rsp_inserted;
   logic        rsp_table_full;

   per_key_change_detect_table #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action_id(req_action_id),
      .req_origin(req_origin),
      .req_level(req_level),
      .req_active(req_active),
      .req_changed_in(req_changed_in),
      .req_now_ticks(req_now_ticks),
      .rsp_valid(rsp_valid),
      .rsp_changed(rsp_changed),
      .rsp_time_written(rsp_time_written),
      .rsp_elapsed_ticks(rsp_elapsed_ticks),
      .rsp_hit(rsp_hit),
      .rsp_inserted(rsp_inserted),
      .rsp_table_full(rsp_table_full)
   );

   always #2 clock = ~clock;

   pending_type samples_to_send[$];
   flags_type   expected_flags[$];
   pending_type cur;
   bit          have_cur = 1'b0;
   int unsigned gap_left = 0;
   logic        took = 1'b0;
   int          errors = 0;
   int          cycle_count = 0;
   bit          burst = 1'b0;

   logic [63:0] known_action[DEPTH];
   logic [63:0] known_origin[DEPTH];
   logic        known_level[DEPTH];
   logic [63:0] known_change[DEPTH];
   int          known_count = 0;

   logic [63:0] pool_action[POOL_SIZE];
   logic [63:0] pool_origin[POOL_SIZE];

   function automatic flags_type lookup_and_update(sample_type s);
      flags_type v;
      int        slot;
      v = '0;
      v.changed = s.changed_in;
      slot = -1;
      if (!s.active)
         return v;
      for (int k = 0; k < known_count; k++)
         if (slot < 0 && known_action[k] == s.action_id && known_origin[k] == s.origin)
            slot = k;
      if (slot >= 0) begin
         v.hit = 1'b1;
         v.changed = (known_level[slot] != s.level);
         if (v.changed) begin
            known_level[slot]  = s.level;
            known_change[slot] = s.now_ticks;
         end
         if (known_change[slot] != 0) begin
            v.time_written  = 1'b1;
            v.elapsed_ticks = s.now_ticks - known_change[slot];
         end
      end else if (known_count >= DEPTH) begin
         v.table_full = 1'b1;
      end else begin
         known_action[known_count] = s.action_id;
         known_origin[known_count] = s.origin;
         known_level[known_count]  = s.level;
         known_change[known_count] = s.now_ticks;
         known_count++;
         v.inserted = 1'b1;
      end
      return v;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch on %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
      errors++;
   endtask

   task automatic add_sample(input logic [63:0] action, input logic [63:0] origin,
                             input logic level, input logic active, input logic changed_in,
                             input logic [63:0] now, input bit drain);
      pending_type p;
      p.s.action_id     = action;
      p.s.origin        = origin;
      p.s.level         = level;
      p.s.active        = active;
      p.s.changed_in    = changed_in;
      p.s.now_ticks     = now;
      p.gap             = burst ? 0 : $urandom_range(0, 5);
      p.drain           = drain;
      samples_to_send.push_back(p);
   endtask

   // driver: hold a word until taken, then count the idle gap once the block is free
   always @(negedge clock) begin
      if (!reset) begin
         if (start && took)
            have_cur = 1'b0;
         if (!(start && !took)) begin
            if (!have_cur && samples_to_send.size() > 0) begin
               cur      = samples_to_send.pop_front();
               have_cur = 1'b1;
               gap_left = cur.gap;
            end
            if (have_cur && gap_left > 0) begin
               if (!busy)
                  gap_left--;
               start <= 1'b0;
            end else if (have_cur && cur.drain && expected_flags.size() != 0) begin
               start <= 1'b0;
            end else if (have_cur) begin
               start          <= 1'b1;
               req_action_id  <= cur.s.action_id;
               req_origin     <= cur.s.origin;
               req_level      <= cur.s.level;
               req_active     <= cur.s.active;
               req_changed_in <= cur.s.changed_in;
               req_now_ticks  <= cur.s.now_ticks;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: check the strobed word first, then predict the word just taken
   always @(posedge clock) begin
      sample_type s;
      flags_type  want;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_valid) begin
            if (expected_flags.size() == 0) begin
               flag_mismatch("unexpected result word", 64'd1, 64'd0);
            end else begin
               want = expected_flags.pop_front();
               if (rsp_changed !== want.changed)
                  flag_mismatch("changed", 64'(rsp_changed), 64'(want.changed));
               if (rsp_time_written !== want.time_written)
                  flag_mismatch("time_written", 64'(rsp_time_written),
                                64'(want.time_written));
               if (rsp_elapsed_ticks !== want.elapsed_ticks)
                  flag_mismatch("elapsed_ticks", rsp_elapsed_ticks, want.elapsed_ticks);
               if (rsp_hit !== want.hit)
                  flag_mismatch("hit", 64'(rsp_hit), 64'(want.hit));
               if (rsp_inserted !== want.inserted)
                  flag_mismatch("inserted", 64'(rsp_inserted), 64'(want.inserted));
               if (rsp_table_full !== want.table_full)
                  flag_mismatch("table_full", 64'(rsp_table_full), 64'(want.table_full));
            end
         end
         if (start && !busy) begin
            s.action_id     = req_action_id;
            s.origin        = req_origin;
            s.level         = req_level;
            s.active        = req_active;
            s.changed_in    = req_changed_in;
            s.now_ticks     = req_now_ticks;
            expected_flags.push_back(lookup_and_update(s));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("** per_key_change_detect_table: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [63:0] ones;
      logic [63:0] now;
      logic [63:0] act;
      logic [63:0] org;
      int          pick;
      int          r;
      int          bit_pos;
      ones = '1;

      for (int k = 0; k < POOL_SIZE; k++) begin
         pool_action[k] = {$urandom, $urandom};
         pool_origin[k] = {$urandom, $urandom};
      end
      pool_action[0] = '0;   pool_origin[0] = '0;
      pool_action[1] = ones; pool_origin[1] = ones;
      pool_action[2] = '0;   pool_origin[2] = ones;
      pool_action[3] = ones; pool_origin[3] = '0;
      // near misses: one bit away from the key in slot 8
      for (int k = 4; k < 8; k++) begin
         bit_pos = $urandom_range(0, 63);
         pool_action[k] = pool_action[8];
         pool_origin[k] = pool_origin[8];
         if (k % 2 == 0)
            pool_action[k][bit_pos] = ~pool_action[k][bit_pos];
         else
            pool_origin[k][bit_pos] = ~pool_origin[k][bit_pos];
      end

      // pass-through, insert at time zero, stored time zero, change, wrap
      add_sample(ones, ones, 1'b1, 1'b0, 1'b1, ones, 1'b0);
      add_sample('0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0);
      add_sample('0, '0, 1'b0, 1'b1, 1'b1, '0, 1'b0);
      add_sample('0, '0, 1'b0, 1'b1, 1'b1, 64'd5, 1'b0);
      add_sample('0, '0, 1'b1, 1'b1, 1'b0, '0, 1'b0);
      add_sample('0, '0, 1'b1, 1'b1, 1'b0, 64'd100, 1'b0);
      add_sample('0, '0, 1'b0, 1'b1, 1'b0, 64'd100, 1'b0);
      add_sample('0, '0, 1'b0, 1'b1, 1'b1, 64'd50, 1'b0);
      add_sample(ones, ones, 1'b1, 1'b1, 1'b0, ones, 1'b0);
      add_sample(ones, ones, 1'b1, 1'b1, 1'b0, 64'd3, 1'b0);
      add_sample(ones, ones, 1'b0, 1'b1, 1'b1, 64'd7, 1'b1);
      add_sample('0, ones, 1'b1, 1'b1, 1'b0, 64'd9, 1'b0);
      add_sample(ones, '0, 1'b0, 1'b1, 1'b1, 64'd11, 1'b0);
      add_sample('0, ones, 1'b0, 1'b0, 1'b1, 64'd13, 1'b0);
      add_sample('0, ones, 1'b1, 1'b1, 1'b1, 64'd15, 1'b0);
      add_sample(pool_action[8], pool_origin[8], 1'b1, 1'b1, 1'b0, 64'd20, 1'b0);
      for (int k = 4; k < 8; k++)
         add_sample(pool_action[k], pool_origin[k], 1'b0, 1'b1, 1'b0, 64'd30 + k, 1'b0);
      add_sample(pool_action[8], pool_origin[8], 1'b0, 1'b1, 1'b1, 64'd40, 1'b0);

      now = 64'd1000;
      for (int n = 0; n < 600; n++) begin
         if (n % 50 == 0)
            burst = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 99);
         if (r < 13) begin
            act = {$urandom, $urandom};
            org = {$urandom, $urandom};
         end else begin
            pick = (r < 60) ? $urandom_range(0, 15) : $urandom_range(0, POOL_SIZE - 1);
            act  = pool_action[pick];
            org  = pool_origin[pick];
         end
         case ($urandom_range(0, 19))
            0: now = {$urandom, $urandom};
            1: now = '0;
            default: now = now + $urandom_range(1, 5000);
         endcase
         add_sample(act, org, 1'($urandom_range(0, 1)), (r >= 8),
                    1'($urandom_range(0, 1)), now,
                    (n % 150 == 75) || ($urandom_range(0, 49) == 0));
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (samples_to_send.size() != 0 || have_cur || expected_flags.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      if (errors == 0 && expected_flags.size() == 0)
         $display("** per_key_change_detect_table: PASSED **");
      else
         $display("** per_key_change_detect_table: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
sv/pkcd_pkg.sv
sv/pkcd_cell.sv
sv/per_key_change_detect_table.sv
sv/pkcd_checker.sv
tb/sv/per_key_change_detect_table_test.sv
